// File: rtl/core/fps_pkg.sv
// Package for the frame playback sequencer: opcodes, play modes, register
// indexes, sequencer states and the playback flag group.
// No dependencies.
package fps_pkg;

   localparam int SPEED_BITS = 20;
   localparam int MODE_BITS  = 3;
   localparam int OP_BITS    = 3;
   localparam int CSR_IDX_BITS = 2;
   localparam logic [1:0] BOUNCE_MAX = 2'd2;

   typedef enum logic [OP_BITS-1:0] {
      OP_TICK       = 3'd0,
      OP_START      = 3'd1,
      OP_PAUSE      = 3'd2,
      OP_RESUME     = 3'd3,
      OP_STOP       = 3'd4,
      OP_STOP_RESET = 3'd5
   } fps_op_type;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_ONESHOT       = 3'd0,
      MODE_LOOP          = 3'd1,
      MODE_ONELOOP       = 3'd2,
      MODE_PINGPONG      = 3'd3,
      MODE_PINGPONG_LOOP = 3'd4
   } fps_mode_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_PLAY_MODE   = 2'd0,
      CSR_RANGE_START = 2'd1,
      CSR_RANGE_END   = 2'd2
   } fps_csr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_DONE
   } fps_state_type;

   typedef struct packed {
      logic       run;
      logic       started;
      logic [1:0] bounce;
   } fps_flags_type;

   localparam fps_flags_type FLAGS_HALTED = '{run: 1'b0, started: 1'b0, bounce: 2'd0};

endpackage

// File: rtl/core/frame_playback_sequencer.sv
// Top level of the frame playback sequencer: configuration registers,
// command sequencer, blend accumulator and result register.
// Depends on fps_pkg and fps_step.
//
// Usage: configure play_mode, range_start and range_end through the csr_
// write port while the block is idle, then send requests on req_ (opcode
// and speed). Each request returns exactly one result on rsp_: the frame,
// the frame being blended toward, the blend fraction, the play state and
// whether the request was accepted.
// Start, pause, resume and the stop commands go from idle straight to the
// done state: the request is taken, and its result is loaded into the result
// register, raising rsp_valid, as soon as that register is free. A tick that
// arrives while playback is not running takes the same path. A running
// tick adds the speed to the accumulator when it is taken, then advances one
// frame per cycle through the shared step unit, up to MAX_STEPS_PER_TICK
// advances, until no advance is left, and then loads its result in the done
// state in the same way.
// The block takes no new request until the current one is done.
// A finished result waits in the result register while rsp_stall is high;
// the sequencer can take the next request meanwhile but holds that result
// until the register is free. Reset clears all playback state and the
// configuration registers to zero and drops rsp_valid.
module frame_playback_sequencer #(
   parameter int FRAME_BITS         = 16,
   parameter int FRACTION_BITS      = 16,
   parameter int MAX_STEPS_PER_TICK = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [fps_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [FRAME_BITS-1:0]               csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [fps_pkg::OP_BITS-1:0]         req_opcode,
   input  logic [fps_pkg::SPEED_BITS-1:0]      req_speed,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [FRAME_BITS-1:0]               rsp_frame,
   output logic signed [FRAME_BITS+1:0]        rsp_next_frame,
   output logic [FRACTION_BITS:0]              rsp_fraction,
   output logic                                rsp_is_playing,
   output logic                                rsp_accepted
);
   import fps_pkg::*;

   localparam int UP_BITS  = FRAME_BITS + 2;
   localparam int ACC_BITS = $clog2((MAX_STEPS_PER_TICK + 1) * (2 ** FRACTION_BITS) + 1);
   localparam int SUM_BITS = (ACC_BITS > SPEED_BITS ? ACC_BITS : SPEED_BITS) + 1;
   localparam int CNT_BITS = $clog2(MAX_STEPS_PER_TICK + 1);
   localparam logic [ACC_BITS-1:0] ONE_FIX = ACC_BITS'(2 ** FRACTION_BITS);
   localparam logic [SUM_BITS-1:0] LIM_FIX =
      SUM_BITS'(MAX_STEPS_PER_TICK * (2 ** FRACTION_BITS));
   localparam logic [SUM_BITS-1:0] CAP_FIX =
      SUM_BITS'((MAX_STEPS_PER_TICK + 1) * (2 ** FRACTION_BITS));
   localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_STEPS_PER_TICK);

   fps_state_type          state_ff, state_in;
   logic [MODE_BITS-1:0]   mode_ff, mode_in;
   logic [FRAME_BITS-1:0]  rstart_ff, rstart_in, rend_ff, rend_in;
   logic [FRAME_BITS-1:0]  cur_ff, cur_in;
   logic [UP_BITS-1:0]     up_ff, up_in;
   logic [ACC_BITS-1:0]    acc_ff, acc_in;
   logic [FRAME_BITS-1:0]  ws_ff, ws_in, we_ff, we_in;
   fps_flags_type          flags_ff, flags_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                   accflag_ff, accflag_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FRAME_BITS-1:0]  rsp_frame_ff;
   logic [UP_BITS-1:0]     rsp_next_ff;
   logic [FRACTION_BITS:0] rsp_frac_ff;
   logic                   rsp_play_ff, rsp_acc_ff;

   logic                   take_req, out_free, load_rsp, step_go, step_more;
   logic [FRAME_BITS-1:0]  st_cur, st_ws, st_we;
   logic [UP_BITS-1:0]     st_up;
   fps_flags_type          st_flags;
   logic [SUM_BITS-1:0]    speed_sat, acc_sum;
   logic [FRACTION_BITS:0] frac_now;

   fps_step #(
      .FRAME_BITS (FRAME_BITS)
   ) u_step (
      .mode_i  (mode_ff),
      .flags_i (flags_ff),
      .up_i    (up_ff),
      .ws_i    (ws_ff),
      .we_i    (we_ff),
      .cur_o   (st_cur),
      .up_o    (st_up),
      .ws_o    (st_ws),
      .we_o    (st_we),
      .flags_o (st_flags)
   );

   assign step_more = (cnt_ff < CNT_MAX) && (acc_ff > ONE_FIX) && flags_ff.run;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_opcode == OP_TICK && flags_ff.run) begin
                  state_in = ST_STEP;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_STEP: begin
            if (!step_more) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = state_ff != ST_IDLE;
      take_req  = state_ff == ST_IDLE && req_valid;
      step_go   = state_ff == ST_STEP && step_more;
      load_rsp  = state_ff == ST_DONE && out_free;
   end

   always_comb begin
      mode_in   = mode_ff;
      rstart_in = rstart_ff;
      rend_in   = rend_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_PLAY_MODE:   mode_in   = csr_wdata[MODE_BITS-1:0];
            CSR_RANGE_START: rstart_in = csr_wdata;
            CSR_RANGE_END:   rend_in   = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cur_in     = cur_ff;
      up_in      = up_ff;
      acc_in     = acc_ff;
      ws_in      = ws_ff;
      we_in      = we_ff;
      flags_in   = flags_ff;
      cnt_in     = cnt_ff;
      accflag_in = accflag_ff;
      speed_sat  = (SUM_BITS'(req_speed) > LIM_FIX) ? LIM_FIX : SUM_BITS'(req_speed);
      acc_sum    = SUM_BITS'(acc_ff) + speed_sat;
      if (take_req) begin
         cnt_in = '0;
         unique case (req_opcode)
            OP_TICK: begin
               accflag_in = 1'b0;
               if (flags_ff.run) begin
                  acc_in = (acc_sum > CAP_FIX) ? CAP_FIX[ACC_BITS-1:0]
                                               : acc_sum[ACC_BITS-1:0];
               end
            end
            OP_START: begin
               accflag_in = rstart_ff != rend_ff;
               if (rstart_ff != rend_ff) begin
                  flags_in = '{run: 1'b1, started: 1'b1, bounce: 2'd0};
                  ws_in    = rstart_ff;
                  we_in    = rend_ff;
                  cur_in   = rstart_ff;
                  if (rend_ff >= rstart_ff) begin
                     up_in = {2'b00, rstart_ff} + UP_BITS'(1);
                  end else begin
                     up_in = {2'b00, rstart_ff} - UP_BITS'(1);
                  end
               end
            end
            OP_PAUSE: begin
               accflag_in = flags_ff.started;
               if (flags_ff.started) begin
                  flags_in.run = 1'b0;
               end
            end
            OP_RESUME: begin
               accflag_in = flags_ff.started;
               if (flags_ff.started) begin
                  flags_in.run = 1'b1;
               end
            end
            OP_STOP: begin
               accflag_in = 1'b1;
               flags_in   = FLAGS_HALTED;
            end
            OP_STOP_RESET: begin
               accflag_in = 1'b1;
               flags_in   = FLAGS_HALTED;
               cur_in     = '0;
               up_in      = '0;
               acc_in     = '0;
            end
            default: begin
               accflag_in = 1'b0;
            end
         endcase
      end else if (step_go) begin
         acc_in   = acc_ff - ONE_FIX;
         cnt_in   = cnt_ff + CNT_BITS'(1);
         cur_in   = st_cur;
         up_in    = st_up;
         ws_in    = st_ws;
         we_in    = st_we;
         flags_in = st_flags;
      end else if (state_ff == ST_STEP) begin
         accflag_in = flags_ff.run;
      end
   end

   always_comb begin
      frac_now     = (acc_ff > ONE_FIX) ? ONE_FIX[FRACTION_BITS:0] : acc_ff[FRACTION_BITS:0];
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= '0;
         rstart_ff    <= '0;
         rend_ff      <= '0;
         cur_ff       <= '0;
         up_ff        <= '0;
         acc_ff       <= '0;
         ws_ff        <= '0;
         we_ff        <= '0;
         flags_ff     <= FLAGS_HALTED;
         cnt_ff       <= '0;
         accflag_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rstart_ff    <= rstart_in;
         rend_ff      <= rend_in;
         cur_ff       <= cur_in;
         up_ff        <= up_in;
         acc_ff       <= acc_in;
         ws_ff        <= ws_in;
         we_ff        <= we_in;
         flags_ff     <= flags_in;
         cnt_ff       <= cnt_in;
         accflag_ff   <= accflag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_frame_ff <= cur_ff;
         rsp_next_ff  <= up_ff;
         rsp_frac_ff  <= frac_now;
         rsp_play_ff  <= flags_ff.run;
         rsp_acc_ff   <= accflag_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame      = rsp_frame_ff;
   assign rsp_next_frame = rsp_next_ff;
   assign rsp_fraction   = rsp_frac_ff;
   assign rsp_is_playing = rsp_play_ff;
   assign rsp_accepted   = rsp_acc_ff;

   a_bounce_sat: assert property (@(posedge clock) disable iff (reset)
      flags_ff.bounce <= BOUNCE_MAX)
      else $error("Bounce count went past its saturation value.");

   a_acc_cap: assert property (@(posedge clock) disable iff (reset)
      SUM_BITS'(acc_ff) <= CAP_FIX)
      else $error("Blend accumulator exceeded its cap.");

   a_step_limit: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_MAX)
      else $error("A tick advanced more frames than allowed.");

   a_run_needs_start: assert property (@(posedge clock) disable iff (reset)
      flags_ff.run |-> flags_ff.started)
      else $error("Playback runs without having been started.");

   a_load_frees_seq: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_valid && state_ff == ST_IDLE)
      else $error("Result load did not release the sequencer.");

endmodule

// File: rtl/core/fps_step.sv
// One frame advance of the playback sequencer, including the range end
// handling for every play mode. Depends on fps_pkg.
module fps_step #(
   parameter int FRAME_BITS = 16
) (
   input  logic [2:0]                   mode_i,
   input  fps_pkg::fps_flags_type       flags_i,
   input  logic [FRAME_BITS+1:0]        up_i,
   input  logic [FRAME_BITS-1:0]        ws_i,
   input  logic [FRAME_BITS-1:0]        we_i,
   output logic [FRAME_BITS-1:0]        cur_o,
   output logic [FRAME_BITS+1:0]        up_o,
   output logic [FRAME_BITS-1:0]        ws_o,
   output logic [FRAME_BITS-1:0]        we_o,
   output fps_pkg::fps_flags_type       flags_o
);
   import fps_pkg::*;

   localparam int UP_BITS = FRAME_BITS + 2;

   always_comb begin
      logic                fwd;
      logic [UP_BITS-1:0]  cur_ext;
      fwd     = we_i >= ws_i;
      cur_o   = up_i[FRAME_BITS-1:0];
      cur_ext = {2'b00, up_i[FRAME_BITS-1:0]};
      up_o    = fwd ? up_i + UP_BITS'(1) : up_i - UP_BITS'(1);
      ws_o    = ws_i;
      we_o    = we_i;
      flags_o = flags_i;
      if (mode_i == MODE_ONELOOP && cur_o == ws_i) begin
         flags_o = FLAGS_HALTED;
      end else if (cur_o == we_i) begin
         if (flags_i.bounce != BOUNCE_MAX) begin
            flags_o.bounce = flags_i.bounce + 2'd1;
         end
         unique case (mode_i)
            MODE_ONESHOT: begin
               flags_o = FLAGS_HALTED;
            end
            MODE_LOOP, MODE_ONELOOP: begin
               up_o = {2'b00, ws_i};
            end
            MODE_PINGPONG, MODE_PINGPONG_LOOP: begin
               if (mode_i == MODE_PINGPONG && flags_o.bounce > 2'd1) begin
                  flags_o = FLAGS_HALTED;
               end else begin
                  ws_o = we_i;
                  we_o = ws_i;
                  if ($signed(up_o) > $signed(cur_ext)) begin
                     up_o = cur_ext - UP_BITS'(1);
                  end else begin
                     up_o = cur_ext + UP_BITS'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule
